>>> design/mlcfc_pkg.sv
// shared types, constants and the crc byte update for the frame checker
package mlcfc_pkg;

  localparam int unsigned CFG_W       = 21;
  localparam int unsigned CRC_BYTES   = 4;
  localparam logic [CFG_W-1:0] MAX_LEN_RST = 21'd4096;
  localparam logic [31:0] MAGIC_WORD  = "MYSF";
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_CRC_ERR  = 2'd3
  } frame_status_e;

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'b0001,
    PH_LENGTH  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CRC     = 4'b1000
  } phase_e;

  // magic bytes beyond the four characters read as zero
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] res;
    case (idx)
      3'd0:    res = MAGIC_WORD[31:24];
      3'd1:    res = MAGIC_WORD[23:16];
      3'd2:    res = MAGIC_WORD[15:8];
      3'd3:    res = MAGIC_WORD[7:0];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> design/magic_length_crc32_frame_checker_core.sv
// length-prefixed frame checker with crc-32: parser, crc update and result register
// Takes one stream byte per cycle on the input channel and gives at most one
// result per byte, in the cycle after the byte is taken, from a single output
// register; a new byte is taken in every cycle while that register is empty or
// being emptied. A frame is the magic, a little-endian length, the payload and a
// little-endian reflected crc-32 of the payload. Each payload byte comes out as a
// payload result; the verdict (ok, bad magic, too long, crc mismatch) comes with
// frame_last_o high. The deepest path is the eight-step crc byte update. The
// maximum payload length register sits at byte address 0 of the register port.
module magic_length_crc32_frame_checker_core #(
  parameter int unsigned MAGIC_BYTES  = 4,
  parameter int unsigned LENGTH_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_verdict_o,
  output logic [7:0]  payload_byte_o,
  output logic [1:0]  frame_status_o,
  output logic [31:0] frame_payload_len_o,
  output logic        frame_last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = mlcfc_pkg::CFG_W;

  mlcfc_pkg::phase_e phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [31:0]   len_q, len_d, crc_q, crc_d, rcrc_q, rcrc_d;
  logic [CW-1:0] max_len_q;

  logic        accept, res_vld;
  logic        res_verdict;
  logic [7:0]  res_byte;
  mlcfc_pkg::frame_status_e res_status;
  logic [31:0] res_len;
  logic [31:0] len_new, rcrc_new;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-CW){1'b0}}, max_len_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= mlcfc_pkg::MAX_LEN_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      max_len_q <= pwdata[CW-1:0];
    end
  end

  assign in_stall_o = out_valid_o && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cnt_inc    = cnt_q + CW'(1);

  always_comb begin
    len_new = len_q;
    len_new[{cnt_q[1:0], 3'b000} +: 8] = data_byte_i;
    rcrc_new = rcrc_q;
    rcrc_new[{cnt_q[1:0], 3'b000} +: 8] = data_byte_i;
  end

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    crc_d       = crc_q;
    rcrc_d      = rcrc_q;
    res_vld     = 1'b0;
    res_verdict = 1'b0;
    res_byte    = 8'h00;
    res_status  = mlcfc_pkg::ST_OK;
    res_len     = 32'h0;
    unique case (phase_q)
      mlcfc_pkg::PH_MAGIC: begin
        if (data_byte_i != mlcfc_pkg::magic_byte(cnt_q[2:0])) begin
          // restart the search, counting the byte if it opens the magic
          cnt_d       = (data_byte_i == mlcfc_pkg::magic_byte(3'd0)) ? CW'(1) : '0;
          len_d       = 32'h0;
          crc_d       = 32'hFFFFFFFF;
          rcrc_d      = 32'h0;
          res_vld     = 1'b1;
          res_verdict = 1'b1;
          res_status  = mlcfc_pkg::ST_BAD_MAGIC;
        end else if (cnt_inc == CW'(MAGIC_BYTES)) begin
          phase_d = mlcfc_pkg::PH_LENGTH;
          cnt_d   = '0;
          len_d   = 32'h0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      mlcfc_pkg::PH_LENGTH: begin
        len_d = len_new;
        cnt_d = cnt_inc;
        if (cnt_inc == CW'(LENGTH_BYTES)) begin
          cnt_d  = '0;
          crc_d  = 32'hFFFFFFFF;
          rcrc_d = 32'h0;
          if (len_new > {{(32-CW){1'b0}}, max_len_q}) begin
            phase_d     = mlcfc_pkg::PH_MAGIC;
            len_d       = 32'h0;
            res_vld     = 1'b1;
            res_verdict = 1'b1;
            res_status  = mlcfc_pkg::ST_TOO_LONG;
            res_len     = len_new;
          end else if (len_new == 32'h0) begin
            phase_d = mlcfc_pkg::PH_CRC;
          end else begin
            phase_d = mlcfc_pkg::PH_PAYLOAD;
          end
        end
      end
      mlcfc_pkg::PH_PAYLOAD: begin
        crc_d    = mlcfc_pkg::crc32_byte(crc_q, data_byte_i);
        cnt_d    = cnt_inc;
        res_vld  = 1'b1;
        res_byte = data_byte_i;
        // length is below 2^21 here, so the count fits
        if ({{(32-CW){1'b0}}, cnt_inc} == len_q) begin
          phase_d = mlcfc_pkg::PH_CRC;
          cnt_d   = '0;
          rcrc_d  = 32'h0;
        end
      end
      mlcfc_pkg::PH_CRC: begin
        rcrc_d = rcrc_new;
        cnt_d  = cnt_inc;
        if (cnt_inc == CW'(mlcfc_pkg::CRC_BYTES)) begin
          phase_d     = mlcfc_pkg::PH_MAGIC;
          cnt_d       = '0;
          len_d       = 32'h0;
          crc_d       = 32'hFFFFFFFF;
          rcrc_d      = 32'h0;
          res_vld     = 1'b1;
          res_verdict = 1'b1;
          res_status  = (rcrc_new == ~crc_q) ? mlcfc_pkg::ST_OK : mlcfc_pkg::ST_CRC_ERR;
          res_len     = len_q;
        end
      end
      default: begin
        phase_d = mlcfc_pkg::PH_MAGIC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mlcfc_pkg::PH_MAGIC;
      cnt_q   <= '0;
      len_q   <= 32'h0;
      crc_q   <= 32'hFFFFFFFF;
      rcrc_q  <= 32'h0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      crc_q   <= crc_d;
      rcrc_q  <= rcrc_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (accept) begin
      out_valid_o <= res_vld;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_vld) begin
      is_verdict_o        <= res_verdict;
      payload_byte_o      <= res_byte;
      frame_status_o      <= res_status;
      frame_payload_len_o <= res_len;
      frame_last_o        <= res_verdict;
    end
  end

endmodule

>>> design/mlcfc_checker.sv
// port-level assertions for the frame checker and their bind
module mlcfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        is_verdict_o,
  input logic [7:0]  payload_byte_o,
  input logic [1:0]  frame_status_o,
  input logic [31:0] frame_payload_len_o,
  input logic        frame_last_o
);

  a_last_marks_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_last_o == is_verdict_o))
    else $error("frame_last differs from is_verdict");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_verdict_o) |->
      (frame_status_o == mlcfc_pkg::ST_OK) && (frame_payload_len_o == 32'h0))
    else $error("payload result carries status or length");

  a_bad_magic_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_verdict_o && (frame_status_o == mlcfc_pkg::ST_BAD_MAGIC)) |->
      (frame_payload_len_o == 32'h0) && (payload_byte_o == 8'h00))
    else $error("bad magic verdict carries data");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while result is held");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(is_verdict_o) && $stable(payload_byte_o) &&
       $stable(frame_status_o) && $stable(frame_payload_len_o)))
    else $error("stalled transaction changed");

endmodule

bind magic_length_crc32_frame_checker_core mlcfc_checker u_mlcfc_checker (.*);

>>> tb/tb_magic_length_crc32_frame_checker_core.sv
// self-checking testbench for the magic/length/crc-32 frame checker core
module tb_magic_length_crc32_frame_checker_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAGIC_LEN   = 4;
  localparam int unsigned LEN_BYTES   = 4;
  localparam logic [2:0]  REG_MAX_LEN = 3'd0;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_BYTES = 170;

  typedef struct packed {
    logic                     is_verdict;
    logic [7:0]               payload;
    mlcfc_pkg::frame_status_e status;
    logic [31:0]              len;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic [7:0]               b;
    logic                     chk;
    mlcfc_pkg::frame_status_e st;
    logic [31:0]              len;
  } byte_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        is_verdict_o;
  logic [7:0]  payload_byte_o;
  logic [1:0]  frame_status_o;
  logic [31:0] frame_payload_len_o;
  logic        frame_last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  magic_length_crc32_frame_checker_core u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .data_byte_i         (data_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .is_verdict_o        (is_verdict_o),
    .payload_byte_o      (payload_byte_o),
    .frame_status_o      (frame_status_o),
    .frame_payload_len_o (frame_payload_len_o),
    .frame_last_o        (frame_last_o),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // parser state mirrored on the testbench side
  mlcfc_pkg::phase_e fc_phase;
  logic [31:0] fc_count;
  logic [31:0] fc_len;
  logic [31:0] fc_crc;
  logic [31:0] fc_rx_crc;
  logic [20:0] max_len_cfg;

  result_t     due_results[$];
  byte_row_t   cur_row;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_long = 1'b0;

  byte_row_t dir_tab [22] = '{
    '{8'h00, 1'b1, mlcfc_pkg::ST_BAD_MAGIC, 32'd0},
    '{8'h4D, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h4D, 1'b1, mlcfc_pkg::ST_BAD_MAGIC, 32'd0},
    '{8'h59, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h53, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h46, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h00, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h00, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h00, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h00, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h00, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h00, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h00, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h00, 1'b1, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h4D, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h59, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h53, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'h46, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'hFF, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'hFF, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'hFF, 1'b0, mlcfc_pkg::ST_OK, 32'd0},
    '{8'hFF, 1'b1, mlcfc_pkg::ST_TOO_LONG, 32'hFFFF_FFFF}
  };

  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = (c >> 1) ^ (fb ? mlcfc_pkg::CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic result_t verdict_of(input mlcfc_pkg::frame_status_e st,
                                         input logic [31:0] len);
    result_t r;
    r            = '0;
    r.is_verdict = 1'b1;
    r.status     = st;
    r.len        = len;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic void restart_search();
    fc_phase  = mlcfc_pkg::PH_MAGIC;
    fc_count  = '0;
    fc_len    = '0;
    fc_crc    = '1;
    fc_rx_crc = '0;
  endfunction

  function automatic void predict_frame_byte(input logic [7:0] b, output bit has_res,
                                             output result_t res);
    logic [7:0]  want_magic;
    logic [31:0] len_seen;
    has_res = 1'b0;
    res     = '0;
    case (fc_phase)
      mlcfc_pkg::PH_MAGIC: begin
        want_magic = (fc_count < 4) ?
                     mlcfc_pkg::MAGIC_WORD[8*(3-fc_count[1:0]) +: 8] : 8'h00;
        if (b != want_magic) begin
          restart_search();
          if (b == mlcfc_pkg::MAGIC_WORD[31:24]) fc_count = 32'd1;
          has_res = 1'b1;
          res     = verdict_of(mlcfc_pkg::ST_BAD_MAGIC, 32'd0);
        end else begin
          fc_count++;
          if (fc_count >= MAGIC_LEN) begin
            fc_phase = mlcfc_pkg::PH_LENGTH;
            fc_count = '0;
            fc_len   = '0;
          end
        end
      end
      mlcfc_pkg::PH_LENGTH: begin
        fc_len |= {24'd0, b} << (8 * fc_count[1:0]);
        fc_count++;
        if (fc_count >= LEN_BYTES) begin
          fc_count  = '0;
          fc_crc    = '1;
          fc_rx_crc = '0;
          if (fc_len > {11'd0, max_len_cfg}) begin
            len_seen = fc_len;
            restart_search();
            has_res = 1'b1;
            res     = verdict_of(mlcfc_pkg::ST_TOO_LONG, len_seen);
          end else begin
            fc_phase = (fc_len == 0) ? mlcfc_pkg::PH_CRC : mlcfc_pkg::PH_PAYLOAD;
          end
        end
      end
      mlcfc_pkg::PH_PAYLOAD: begin
        fc_crc = crc32_update(fc_crc, b);
        fc_count++;
        if (fc_count >= fc_len) begin
          fc_phase  = mlcfc_pkg::PH_CRC;
          fc_count  = '0;
          fc_rx_crc = '0;
        end
        has_res     = 1'b1;
        res.payload = b;
      end
      default: begin
        fc_rx_crc |= {24'd0, b} << (8 * fc_count[1:0]);
        fc_count++;
        if (fc_count >= mlcfc_pkg::CRC_BYTES) begin
          len_seen = fc_len;
          has_res  = 1'b1;
          res      = verdict_of((fc_rx_crc == ~fc_crc) ? mlcfc_pkg::ST_OK :
                                mlcfc_pkg::ST_CRC_ERR, len_seen);
          restart_search();
        end
      end
    endcase
  endfunction

  function automatic void cmp_field(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result check first, then prediction for the byte taken at this edge
  always @(posedge clk_i) begin
    result_t want;
    result_t pred;
    bit      has_res;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          cmp_field("is_verdict", 32'(want.is_verdict), 32'(is_verdict_o));
          cmp_field("payload_byte", 32'(want.payload), 32'(payload_byte_o));
          cmp_field("frame_status", 32'(want.status), 32'(frame_status_o));
          cmp_field("frame_payload_len", want.len, frame_payload_len_o);
          cmp_field("frame_last", 32'(want.last), 32'(frame_last_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_frame_byte(data_byte_i, has_res, pred);
        if (cur_row.chk) due_results.push_back(verdict_of(cur_row.st, cur_row.len));
        else if (has_res) due_results.push_back(pred);
      end
    end
  end

  // receiver side stalls
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        hold_long = 1'b0;
        out_stall_i <= 1'b1;
        repeat (80) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic offer(input byte_row_t r);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= r.b;
    cur_row     <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_random_segment(inout int unsigned sent);
    logic [7:0]  seq[$];
    logic [31:0] len;
    logic [31:0] crc;
    int unsigned cap;
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      for (int k = 0; k < 4; k++) seq.push_back(mlcfc_pkg::MAGIC_WORD[8*(3-k) +: 8]);
      if (pick < 75) begin
        cap = (max_len_cfg < 21'd24) ? 32'(max_len_cfg) : 24;
        if ($urandom_range(0, 9) == 0) cap = (max_len_cfg < 21'd300) ? 32'(max_len_cfg) : 300;
        len = $urandom_range(0, cap);
        if ($urandom_range(0, 7) == 0 && max_len_cfg <= 21'd300) len = {11'd0, max_len_cfg};
      end else begin
        case ($urandom_range(0, 2))
          0:       len = 32'hFFFF_FFFF;
          1:       len = {11'd0, max_len_cfg} + 32'd1;
          default: len = $urandom | 32'h0040_0000;
        endcase
      end
      for (int k = 0; k < 4; k++) seq.push_back(len[8*k +: 8]);
      if (pick < 75) begin
        crc = '1;
        for (int unsigned k = 0; k < len; k++) begin
          seq.push_back(8'($urandom));
          crc = crc32_update(crc, seq[seq.size()-1]);
        end
        crc = ~crc;
        // corrupted crc on part of the frames
        if (pick >= 60) crc ^= 32'd1 << $urandom_range(0, 31);
        for (int k = 0; k < 4; k++) seq.push_back(crc[8*k +: 8]);
      end
    end else if (pick < 93) begin
      // magic cut short by a random byte
      cut = $urandom_range(0, 3);
      for (int k = 0; k < cut; k++) seq.push_back(mlcfc_pkg::MAGIC_WORD[8*(3-k) +: 8]);
      seq.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom));
    end
    foreach (seq[i]) offer(byte_row_t'{seq[i], 1'b0, mlcfc_pkg::ST_OK, 32'd0});
    sent += seq.size();
  endtask

  initial begin
    logic [31:0] rd;
    logic [31:0] cfg;
    int unsigned sent;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    cur_row     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    restart_search();
    max_len_cfg = mlcfc_pkg::MAX_LEN_RST;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    apb_access(1'b0, REG_MAX_LEN, 32'd0, rd);
    cmp_field("max_payload_len", 32'(mlcfc_pkg::MAX_LEN_RST), rd);

    foreach (dir_tab[i]) offer(dir_tab[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1:       cfg = 32'd0;
          2:       cfg = 32'd1048576;
          3:       cfg = 32'hFFFF_FFFF;
          4:       cfg = $urandom_range(1, 40);
          default: cfg = 32'd4096;
        endcase
        apb_access(1'b1, REG_MAX_LEN, cfg, rd);
        max_len_cfg = cfg[20:0];
        apb_access(1'b0, REG_MAX_LEN, 32'd0, rd);
        cmp_field("max_payload_len", {11'd0, cfg[20:0]}, rd);
      end
      calm = (p == PHASES - 1);
      if (p == 2) hold_long = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) send_random_segment(sent);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> magic_length_crc32_frame_checker_core.f
design/mlcfc_pkg.sv
design/magic_length_crc32_frame_checker_core.sv
design/mlcfc_checker.sv
tb/tb_magic_length_crc32_frame_checker_core.sv
